/* hw/rtl/wad_pkg.sv */
// shared types and constants for the weighted average decimator
// no dependencies; imported by every module of the block
`default_nettype none

package wad_pkg;

    localparam int CHAN_W    = 32;
    localparam int NUM_CHAN  = 4;
    localparam int STEP_W    = 11;
    localparam int MASK_W    = 4;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STEP   = 2'd0,
        CFG_ENABLE = 2'd1,
        CFG_PASS   = 2'd2
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAC,
        ST_DEN,
        ST_DIV,
        ST_WRITE
    } t_state;

    typedef struct packed {
        logic signed [CHAN_W-1:0] chan3_value;
        logic signed [CHAN_W-1:0] chan2_value;
        logic signed [CHAN_W-1:0] chan1_value;
        logic signed [CHAN_W-1:0] chan0_value;
    } t_in_item;

    typedef struct packed {
        logic signed [CHAN_W-1:0] chan3_avg;
        logic signed [CHAN_W-1:0] chan2_avg;
        logic signed [CHAN_W-1:0] chan1_avg;
        logic signed [CHAN_W-1:0] chan0_avg;
        logic        [MASK_W-1:0] present_mask;
    } t_out_item;

    typedef struct packed {
        logic mac_load;
        logic mac_step;
        logic div_load;
        logic div_step;
    } t_lane_ctl;

endpackage

`default_nettype wire

/* hw/rtl/wad_mac_lane.sv */
// one channel of the bit-serial multiply-accumulate: serial-parallel multiplier
// feeding a rotating accumulator with a one-bit adder; depends on wad_pkg
`default_nettype none

module wad_mac_lane
    import wad_pkg::*;
#(
    parameter int ACC_W = 52,
    parameter int POS_W = 11
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_lane_ctl         i_ctl,
    input  wire logic [CHAN_W-1:0] i_value,
    input  wire logic [POS_W-1:0]  i_size,
    output logic      [ACC_W-1:0]  o_acc
);

    logic [ACC_W-1:0]  r_acc;
    logic [CHAN_W-1:0] r_x;
    logic [POS_W-1:0]  r_pp;
    logic              r_c;

    logic [POS_W:0]    w_t;
    logic              w_pb;
    logic              w_sum;
    logic              w_cout;

    // partial product plus size when the current multiplicand bit is set
    assign w_t    = {1'b0, r_pp} + (r_x[0] ? {1'b0, i_size} : '0);
    assign w_pb   = w_t[0];
    assign w_sum  = r_acc[0] ^ w_pb ^ r_c;
    assign w_cout = (r_acc[0] & w_pb) | (r_acc[0] & r_c) | (w_pb & r_c);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (i_ctl.div_load) begin
            r_acc <= '0;
        end else if (i_ctl.mac_step) begin
            r_acc <= {w_sum, r_acc[ACC_W-1:1]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.mac_load) begin
            r_x  <= i_value;
            r_pp <= '0;
            r_c  <= 1'b0;
        end else if (i_ctl.mac_step) begin
            // sign bit is replicated so the multiplicand runs sign-extended
            r_x  <= {r_x[CHAN_W-1], r_x[CHAN_W-1:1]};
            r_pp <= w_t[POS_W:1];
            r_c  <= w_cout;
        end
    end

    assign o_acc = r_acc;

endmodule

`default_nettype wire

/* hw/rtl/wad_div_lane.sv */
// one channel of the restoring divider, one quotient bit per cycle
// divides the accumulator magnitude and restores the sign; depends on wad_pkg
`default_nettype none

module wad_div_lane
    import wad_pkg::*;
#(
    parameter int ACC_W = 52,
    parameter int DEN_W = 20
) (
    input  wire logic              i_clk,
    input  wire t_lane_ctl         i_ctl,
    input  wire logic [ACC_W-1:0]  i_acc,
    input  wire logic [DEN_W-1:0]  i_den,
    output logic      [CHAN_W-1:0] o_quot
);

    logic [ACC_W-1:0]  r_num;
    logic [DEN_W-1:0]  r_rem;
    logic [CHAN_W-1:0] r_q;
    logic              r_neg;

    logic [DEN_W:0]    w_trial;
    logic [DEN_W:0]    w_diff;
    logic              w_ge;

    assign w_trial = {r_rem, r_num[ACC_W-1]};
    assign w_diff  = w_trial - {1'b0, i_den};
    assign w_ge    = (w_trial >= {1'b0, i_den});

    always_ff @(posedge i_clk) begin
        if (i_ctl.div_load) begin
            r_neg <= i_acc[ACC_W-1];
            r_num <= i_acc[ACC_W-1] ? (~i_acc + 1'b1) : i_acc;
            r_rem <= '0;
            r_q   <= '0;
        end else if (i_ctl.div_step) begin
            r_num <= {r_num[ACC_W-2:0], 1'b0};
            r_rem <= w_ge ? w_diff[DEN_W-1:0] : w_trial[DEN_W-1:0];
            // only the low word of the quotient is kept
            r_q   <= {r_q[CHAN_W-2:0], w_ge};
        end
    end

    // truncation toward zero: divide the magnitude, then negate
    assign o_quot = r_neg ? (~r_q + 1'b1) : r_q;

endmodule

`default_nettype wire

/* hw/rtl/wad_ctrl.sv */
// sequencer: window position, bit counter, denominator and lane control
// depends on wad_pkg
`default_nettype none

module wad_ctrl
    import wad_pkg::*;
#(
    parameter int ACC_W = 52,
    parameter int POS_W = 11,
    parameter int DEN_W = 20
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire logic             i_out_free,
    input  wire logic [POS_W-1:0] i_eff_step,
    output t_lane_ctl             o_ctl,
    output logic      [POS_W-1:0] o_size,
    output logic      [DEN_W-1:0] o_den,
    output logic                  o_out_load
);

    localparam int CNT_W = $clog2(ACC_W);

    t_state           r_state;
    t_state           n_state;
    logic [POS_W-1:0] r_pos;
    logic [POS_W-1:0] r_size;
    logic [DEN_W-1:0] r_den;
    logic [CNT_W-1:0] r_cnt;

    logic             w_accept;
    logic             w_last;
    logic             w_close;
    logic [2*POS_W:0] w_sz_ext;
    logic [2*POS_W:0] w_prod;

    assign w_accept = (r_state == ST_IDLE) && i_in_valid;
    assign w_last   = (r_cnt == CNT_W'(ACC_W - 1));
    assign w_close  = (r_size >= i_eff_step);
    assign w_sz_ext = {{(POS_W+1){1'b0}}, r_size};
    assign w_prod   = w_sz_ext * (w_sz_ext + 1'b1);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_MAC;
            end
            ST_MAC: begin
                if (w_last) n_state = w_close ? ST_DEN : ST_IDLE;
            end
            ST_DEN: begin
                n_state = ST_DIV;
            end
            ST_DIV: begin
                if (w_last) n_state = ST_WRITE;
            end
            ST_WRITE: begin
                if (i_out_free) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        o_in_ready     = 1'b0;
        o_ctl          = '0;
        o_out_load     = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready   = 1'b1;
                o_ctl.mac_load = i_in_valid;
            end
            ST_MAC: begin
                o_ctl.mac_step = 1'b1;
            end
            ST_DEN: begin
                o_ctl.div_load = 1'b1;
            end
            ST_DIV: begin
                o_ctl.div_step = 1'b1;
            end
            ST_WRITE: begin
                o_out_load = i_out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pos   <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if (w_accept || r_state == ST_DEN) begin
                r_cnt <= '0;
            end else if (r_state == ST_MAC || r_state == ST_DIV) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (r_state == ST_MAC && w_last) begin
                r_pos <= w_close ? '0 : r_size;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_size <= r_pos + 1'b1;
        end
        // triangular number of the samples actually in the window
        if (r_state == ST_DEN) begin
            r_den <= w_prod[DEN_W:1];
        end
    end

    assign o_size = r_size;
    assign o_den  = r_den;

    a_accept_starts_mac: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> o_ctl.mac_step)
        else $error("request accepted but accumulation did not start");

    a_div_after_mac: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctl.div_load |-> ($past(r_state) == ST_MAC))
        else $error("divider loaded without a finished accumulation");

    a_div_only_on_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctl.div_load |-> (r_size >= i_eff_step))
        else $error("window closed before reaching the step");

endmodule

`default_nettype wire

/* hw/rtl/weighted_average_decimator_top.sv */
// top level of the weighted average decimator: configuration registers,
// channel lanes and output register; depends on wad_pkg, wad_ctrl, wad_mac_lane, wad_div_lane
`default_nettype none

// Each accepted request is one sample of all four channels. Every enabled,
// averaged channel adds sample times window position into a bit-serial
// accumulator of ACC_W bits (52 at the default MAX_STEP of 1024), one bit per
// cycle. The sample that closes the window then runs a restoring divider over
// the same ACC_W bits before the result sits in the output register. The
// result register frees the input side: the next sample is taken while a
// result waits, and only a second closing window waits for it to drain.
// Reset needs no clearing pass. Configuration is written through its own
// channel, which is always ready; the user must write it only while the block
// is idle, as the block itself does not enforce this.
module weighted_average_decimator_top
    import wad_pkg::*;
#(
    parameter int MAX_STEP = 1024
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [STEP_W-1:0]    i_cfg_data,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire t_in_item             i_in_data,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output t_out_item                 o_out_data
);

    localparam int     POS_W = $clog2(MAX_STEP + 1);
    localparam longint TRI   = (longint'(MAX_STEP) * (longint'(MAX_STEP) + 1)) / 2;
    localparam int     DEN_W = $clog2(TRI + 1);
    localparam int     ACC_W = CHAN_W + DEN_W;

    logic [STEP_W-1:0] r_step;
    logic [MASK_W-1:0] r_en;
    logic [MASK_W-1:0] r_pass;
    t_in_item          r_in;
    t_out_item         r_out;
    logic              r_out_valid;

    logic [31:0]       w_step_ext;
    logic [POS_W-1:0]  w_eff;
    logic              w_out_free;
    logic              w_out_load;
    t_lane_ctl         w_ctl;
    logic [POS_W-1:0]  w_size;
    logic [DEN_W-1:0]  w_den;

    logic [CHAN_W-1:0] w_new_val [NUM_CHAN];
    logic [CHAN_W-1:0] w_cur_val [NUM_CHAN];
    logic [CHAN_W-1:0] w_mac_val [NUM_CHAN];
    logic [ACC_W-1:0]  w_acc     [NUM_CHAN];
    logic [CHAN_W-1:0] w_quot    [NUM_CHAN];
    logic [CHAN_W-1:0] w_res     [NUM_CHAN];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= STEP_W'(1);
            r_en   <= '1;
            r_pass <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_STEP:   r_step <= i_cfg_data;
                CFG_ENABLE: r_en   <= i_cfg_data[MASK_W-1:0];
                CFG_PASS:   r_pass <= i_cfg_data[MASK_W-1:0];
                default:    r_step <= r_step;
            endcase
        end
    end

    // step of zero acts as one, anything above MAX_STEP saturates
    assign w_step_ext = 32'(r_step);
    always_comb begin
        if (r_step == '0) begin
            w_eff = POS_W'(1);
        end else if (w_step_ext > 32'(MAX_STEP)) begin
            w_eff = POS_W'(MAX_STEP);
        end else begin
            w_eff = POS_W'(w_step_ext);
        end
    end

    assign w_new_val[0] = i_in_data.chan0_value;
    assign w_new_val[1] = i_in_data.chan1_value;
    assign w_new_val[2] = i_in_data.chan2_value;
    assign w_new_val[3] = i_in_data.chan3_value;
    assign w_cur_val[0] = r_in.chan0_value;
    assign w_cur_val[1] = r_in.chan1_value;
    assign w_cur_val[2] = r_in.chan2_value;
    assign w_cur_val[3] = r_in.chan3_value;

    always_ff @(posedge i_clk) begin
        if (w_ctl.mac_load) begin
            r_in <= i_in_data;
        end
    end

    assign w_out_free = !r_out_valid || i_out_ready;

    wad_ctrl #(
        .ACC_W (ACC_W),
        .POS_W (POS_W),
        .DEN_W (DEN_W)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_out_free (w_out_free),
        .i_eff_step (w_eff),
        .o_ctl      (w_ctl),
        .o_size     (w_size),
        .o_den      (w_den),
        .o_out_load (w_out_load)
    );

    for (genvar c = 0; c < NUM_CHAN; c++) begin : g_lane
        // channels that are off or passed through add nothing
        assign w_mac_val[c] = (r_en[c] && !r_pass[c]) ? w_new_val[c] : '0;

        wad_mac_lane #(
            .ACC_W (ACC_W),
            .POS_W (POS_W)
        ) u_mac (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl),
            .i_value (w_mac_val[c]),
            .i_size  (w_size),
            .o_acc   (w_acc[c])
        );

        wad_div_lane #(
            .ACC_W (ACC_W),
            .DEN_W (DEN_W)
        ) u_div (
            .i_clk  (i_clk),
            .i_ctl  (w_ctl),
            .i_acc  (w_acc[c]),
            .i_den  (w_den),
            .o_quot (w_quot[c])
        );

        assign w_res[c] = !r_en[c]  ? '0 :
                          r_pass[c] ? w_cur_val[c] : w_quot[c];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out.chan0_avg    <= w_res[0];
            r_out.chan1_avg    <= w_res[1];
            r_out.chan2_avg    <= w_res[2];
            r_out.chan3_avg    <= w_res[3];
            r_out.present_mask <= r_en;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

/* tb/weighted_average_decimator_top_tb.sv */
// self-checking testbench for the weighted average decimator top level
// depends on wad_pkg and weighted_average_decimator_top; predicts each window result itself
`default_nettype none

module weighted_average_decimator_top_tb;
    import wad_pkg::*;

    localparam int MAX_STEP     = 1024;
    localparam int ACC_W        = 52;
    localparam int DRAIN_CYCLES = 150;
    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int SMALL_TARGET = 860;
    localparam int SAT_SAMPLES  = 40;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [STEP_W-1:0]    cfg_data = '0;
    logic                 in_valid = 1'b0;
    t_in_item             in_data = '0;
    logic                 out_ready = 1'b0;
    logic                 cfg_ready;
    logic                 in_ready;
    logic                 out_valid;
    t_out_item            out_data;

    // predictor state
    logic [STEP_W-1:0]        step_reg;
    logic [MASK_W-1:0]        enable_reg;
    logic [MASK_W-1:0]        pass_reg;
    logic [STEP_W-1:0]        win_fill;
    logic signed [ACC_W-1:0]  acc [NUM_CHAN];

    t_in_item  samples_pending [$];
    t_out_item averages_due [$];
    int        samples_sent = 0;
    int        samples_taken = 0;
    int        mismatches = 0;
    int        cycle_count = 0;
    int        send_idle_pct = 0;
    int        recv_idle_pct = 0;

    weighted_average_decimator_top #(
        .MAX_STEP(MAX_STEP)
    ) dut (
        .i_clk(clk),
        .i_rst_n(rst_n),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index),
        .i_cfg_data(cfg_data),
        .i_in_valid(in_valid),
        .o_in_ready(in_ready),
        .i_in_data(in_data),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_data(out_data)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("weighted_average_decimator_top_tb: FAIL");
            $finish;
        end
    end

    function automatic void reset_model();
        int c;
        step_reg   = 11'd1;
        enable_reg = 4'hF;
        pass_reg   = 4'h0;
        win_fill   = '0;
        for (c = 0; c < NUM_CHAN; c++) acc[c] = '0;
    endfunction

    // adds one sample to the window; closes it when full
    function automatic void take_sample(input t_in_item s);
        logic signed [CHAN_W-1:0] raw [NUM_CHAN];
        logic signed [CHAN_W-1:0] avg [NUM_CHAN];
        logic [STEP_W-1:0]        span;
        logic [STEP_W-1:0]        fill;
        logic signed [ACC_W-1:0]  denom;
        logic signed [ACC_W-1:0]  quot;
        t_out_item                res;
        int                       c;
        raw[0] = s.chan0_value;
        raw[1] = s.chan1_value;
        raw[2] = s.chan2_value;
        raw[3] = s.chan3_value;
        span = (step_reg == 0) ? 11'd1 : (step_reg > MAX_STEP) ? STEP_W'(MAX_STEP) : step_reg;
        fill = win_fill + 1'b1;
        for (c = 0; c < NUM_CHAN; c++) begin
            if (enable_reg[c] && !pass_reg[c])
                acc[c] = acc[c] + raw[c] * $signed({1'b0, fill});
        end
        if (fill < span) begin
            win_fill = fill;
            return;
        end
        denom = (fill * (fill + 1)) / 2;
        for (c = 0; c < NUM_CHAN; c++) begin
            avg[c] = '0;
            if (enable_reg[c]) begin
                if (pass_reg[c]) begin
                    avg[c] = raw[c];
                end else begin
                    quot   = acc[c] / denom;
                    avg[c] = quot[CHAN_W-1:0];
                end
            end
            acc[c] = '0;
        end
        res.chan0_avg    = avg[0];
        res.chan1_avg    = avg[1];
        res.chan2_avg    = avg[2];
        res.chan3_avg    = avg[3];
        res.present_mask = enable_reg;
        averages_due.push_back(res);
        win_fill = '0;
    endfunction

    // sample driver
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready) begin
                take_sample(in_data);
                samples_taken <= samples_taken + 1;
            end
            if (!in_valid || in_ready) begin
                if (samples_pending.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    in_valid <= 1'b1;
                    in_data  <= samples_pending.pop_front();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(input string name, input logic [CHAN_W-1:0] want,
                               input logic [CHAN_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %h got %h", $time, name, want, got);
            mismatches++;
        end
    endtask

    // result monitor
    always @(posedge clk) begin
        t_out_item want;
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                if (averages_due.size() == 0) begin
                    $display("%0t: result with none expected: expected none got %h",
                             $time, out_data);
                    mismatches++;
                end else begin
                    want = averages_due.pop_front();
                    check_field("chan0_avg", want.chan0_avg, out_data.chan0_avg);
                    check_field("chan1_avg", want.chan1_avg, out_data.chan1_avg);
                    check_field("chan2_avg", want.chan2_avg, out_data.chan2_avg);
                    check_field("chan3_avg", want.chan3_avg, out_data.chan3_avg);
                    check_field("present_mask", want.present_mask, out_data.present_mask);
                end
            end
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic queue_sample(input logic [CHAN_W-1:0] v0, input logic [CHAN_W-1:0] v1,
                                input logic [CHAN_W-1:0] v2, input logic [CHAN_W-1:0] v3);
        t_in_item s;
        s.chan0_value = v0;
        s.chan1_value = v1;
        s.chan2_value = v2;
        s.chan3_value = v3;
        samples_pending.push_back(s);
        samples_sent++;
    endtask

    function automatic logic [CHAN_W-1:0] pick_value();
        case ($urandom_range(9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            4: return CHAN_W'($signed($urandom_range(0, 200)) - 100);
            default: return $urandom;
        endcase
    endfunction

    task automatic wait_drained();
        while (samples_taken != samples_sent || averages_due.size() != 0) @(posedge clk);
    endtask

    // a sample that closes no window may still be in the accumulators
    task automatic settle();
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [STEP_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        case (idx)
            CFG_STEP:   step_reg   = val;
            CFG_ENABLE: enable_reg = val[MASK_W-1:0];
            CFG_PASS:   pass_reg   = val[MASK_W-1:0];
            default: ;
        endcase
        cfg_valid <= 1'b0;
    endtask

    initial begin
        int                rnd_count;
        int                burst;
        int                phase;
        int                i;
        logic [STEP_W-1:0] step_val;
        reset_model();
        send_idle_pct = 20;
        recv_idle_pct = 64;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // extremes at the reset settings, one result per sample
        queue_sample(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF);
        queue_sample(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000);
        queue_sample(32'h0000_0001, 32'hFFFF_FFFF, 32'h1234_5678, 32'hFAC6_8B4F);
        settle();
        // zero step behaves as one
        write_reg(CFG_STEP, 11'd0);
        queue_sample(32'hFFFF_FFF9, 32'h0000_0007, 32'h8000_0001, 32'h7FFF_FFFE);
        settle();
        // pass-through on enabled and disabled channels, mask upper data bits set
        write_reg(CFG_STEP, 11'd3);
        write_reg(CFG_ENABLE, 11'h7FB);
        write_reg(CFG_PASS, 11'h7F6);
        queue_sample(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        queue_sample(32'h7FFF_FFFF, 32'h0000_0005, 32'h7FFF_FFFF, 32'h8000_0000);
        queue_sample(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        settle();
        // largest step, then lowered mid-window so the next sample closes it
        write_reg(CFG_STEP, 11'd1024);
        write_reg(CFG_ENABLE, 11'h00F);
        write_reg(CFG_PASS, 11'h000);
        queue_sample(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFD);
        queue_sample(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0002);
        settle();
        write_reg(CFG_STEP, 11'd1);
        queue_sample(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        settle();
        // masks changed mid-window; unused index is ignored
        write_reg(CFG_STEP, 11'd4);
        queue_sample(32'h0000_0064, 32'hFFFF_FF9C, 32'h7FFF_FFFF, 32'h8000_0000);
        queue_sample(32'h0000_0064, 32'hFFFF_FF9C, 32'h7FFF_FFFF, 32'h8000_0000);
        settle();
        write_reg(CFG_ENABLE, 11'd5);
        write_reg(CFG_PASS, 11'd1);
        write_reg(CFG_UNUSED, 11'h7FF);
        queue_sample(32'hFFFF_FFFF, 32'h0000_0003, 32'hFFFF_FFFB, 32'h0000_0009);
        queue_sample(32'h8000_0000, 32'h0000_0003, 32'hFFFF_FFFB, 32'h0000_0009);

        rnd_count = 0;
        phase = 0;
        while (rnd_count < SMALL_TARGET) begin
            if (rnd_count < SMALL_TARGET / 3) begin
                send_idle_pct = 20;
                recv_idle_pct = 64;
            end else if (rnd_count < 2 * SMALL_TARGET / 3) begin
                send_idle_pct = 64;
                recv_idle_pct = 20;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            settle();
            case ($urandom_range(9))
                0:       step_val = 11'd0;
                1:       step_val = STEP_W'($urandom_range(9, 40));
                default: step_val = STEP_W'($urandom_range(1, 6));
            endcase
            // skipping some writes leaves partial windows under changed settings
            if ($urandom_range(2) != 0) write_reg(CFG_STEP, step_val);
            if ($urandom_range(2) != 0) write_reg(CFG_ENABLE, STEP_W'($urandom_range(0, 2047)));
            if ($urandom_range(2) != 0) write_reg(CFG_PASS, STEP_W'($urandom_range(0, 2047)));
            burst = $urandom_range(15, 45);
            for (i = 0; i < burst; i++) begin
                // hold the sender once until every pending result is out
                if (phase == 4 && i == burst / 2) wait_drained();
                queue_sample(pick_value(), pick_value(), pick_value(), pick_value());
            end
            rnd_count += burst;
            phase++;
        end

        // saturated step: a long run of samples closes no window
        settle();
        write_reg(CFG_STEP, 11'h7FF);
        write_reg(CFG_ENABLE, STEP_W'($urandom_range(0, 2047)));
        write_reg(CFG_PASS, STEP_W'($urandom_range(0, 2047)));
        for (i = 0; i < SAT_SAMPLES; i++)
            queue_sample(pick_value(), pick_value(), pick_value(), pick_value());
        settle();
        // lowering the step lets the next sample close the long window
        write_reg(CFG_STEP, 11'd1);
        queue_sample(pick_value(), pick_value(), pick_value(), pick_value());

        settle();
        if (mismatches == 0 && averages_due.size() == 0) begin
            $display("weighted_average_decimator_top_tb: PASS");
        end else begin
            $display("weighted_average_decimator_top_tb: FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire
